>>> src/u2u_pkg.sv
package u2u_pkg;

  // one input beat: a raw utf-8 byte and its end-of-string mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  // one result beat
  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_error;
    logic        last_unit;
  } result_t;

  // lead byte classes
  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;

  // payload bits kept from each byte kind
  localparam logic [7:0] LEAD2_BITS = 8'h1F;
  localparam logic [7:0] LEAD3_BITS = 8'h0F;
  localparam logic [7:0] CONT_BITS  = 8'h3F;

  // continuation counts
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

endpackage

>>> src/u2u_in_stage.sv
module u2u_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  u2u_pkg::item_t in_item,
  input  logic          advance,
  output logic          held_valid,
  output u2u_pkg::item_t held_item
);

  logic          valid;
  logic          valid_next;
  u2u_pkg::item_t item;

  // slot takes a new beat when empty or emptying this cycle
  assign in_ready   = !valid || advance;
  assign held_valid = valid;
  assign held_item  = item;

  // valid flag
  always_comb begin
    valid_next = valid;
    if (in_valid && in_ready) begin
      valid_next = 1'b1;
    end else if (advance) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

>>> src/u2u_decode.sv
module u2u_decode (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  u2u_pkg::item_t   item,
  output logic             res_valid,
  output u2u_pkg::result_t res
);

  logic [1:0]  bytes_pending;
  logic [1:0]  bytes_pending_next;
  logic [9:0]  partial_value;
  logic [9:0]  partial_value_next;
  logic        string_invalid;
  logic        string_invalid_next;

  logic [7:0]  b;
  logic [15:0] joined;
  logic [1:0]  pend_dec;

  assign b        = item.data_byte;
  assign joined   = {partial_value, b[5:0] & u2u_pkg::CONT_BITS[5:0]};
  assign pend_dec = bytes_pending - 2'd1;

  // per-byte decode and next state
  always_comb begin
    bytes_pending_next  = bytes_pending;
    partial_value_next  = partial_value;
    string_invalid_next = string_invalid;
    res_valid           = 1'b0;
    res                 = '0;
    if (item_valid) begin
      if (string_invalid) begin
        // dropping bytes until the end of the string
        if (item.last_byte) begin
          string_invalid_next = 1'b0;
          res_valid           = 1'b1;
          res.is_error        = 1'b1;
          res.last_unit       = 1'b1;
        end
      end else if (bytes_pending != u2u_pkg::PEND_NONE) begin
        // continuation byte
        if (pend_dec == u2u_pkg::PEND_NONE) begin
          bytes_pending_next = u2u_pkg::PEND_NONE;
          partial_value_next = '0;
          res_valid          = 1'b1;
          res.code_unit      = joined;
          res.last_unit      = item.last_byte;
        end else if (item.last_byte) begin
          bytes_pending_next = u2u_pkg::PEND_NONE;
          partial_value_next = '0;
          res_valid          = 1'b1;
          res.is_error       = 1'b1;
          res.last_unit      = 1'b1;
        end else begin
          bytes_pending_next = pend_dec;
          partial_value_next = joined[9:0];
        end
      end else if ((b & u2u_pkg::ASCII_MASK) == 8'h00) begin
        // single byte character
        res_valid     = 1'b1;
        res.code_unit = {8'h00, b};
        res.last_unit = item.last_byte;
      end else begin
        // multi-byte lead or invalid lead
        if ((b & u2u_pkg::LEAD2_MASK) == u2u_pkg::LEAD2_CODE) begin
          bytes_pending_next = u2u_pkg::PEND_ONE;
          partial_value_next = {2'b00, b & u2u_pkg::LEAD2_BITS};
        end else if ((b & u2u_pkg::LEAD3_MASK) == u2u_pkg::LEAD3_CODE) begin
          bytes_pending_next = u2u_pkg::PEND_TWO;
          partial_value_next = {2'b00, b & u2u_pkg::LEAD3_BITS};
        end else begin
          string_invalid_next = 1'b1;
        end
        if (item.last_byte) begin
          bytes_pending_next  = u2u_pkg::PEND_NONE;
          partial_value_next  = '0;
          string_invalid_next = 1'b0;
          res_valid           = 1'b1;
          res.is_error        = 1'b1;
          res.last_unit       = 1'b1;
        end
      end
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending  <= u2u_pkg::PEND_NONE;
      partial_value  <= '0;
      string_invalid <= 1'b0;
    end else begin
      bytes_pending  <= bytes_pending_next;
      partial_value  <= partial_value_next;
      string_invalid <= string_invalid_next;
    end
  end

  // checks
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.is_error |-> res.last_unit && res.code_unit == 16'h0000)
    else $error("error result without last mark or with nonzero unit");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    item_valid && item.last_byte |=>
      bytes_pending == u2u_pkg::PEND_NONE && partial_value == 10'd0 && !string_invalid)
    else $error("decoder state not cleared after final byte");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && item.last_byte |-> res_valid && res.last_unit)
    else $error("final byte gave no final result");

  a_pend_range: assert property (@(posedge clk) disable iff (rst)
    bytes_pending != 2'd3 && !(string_invalid && bytes_pending != u2u_pkg::PEND_NONE))
    else $error("continuation count out of range");

endmodule

>>> src/u2u_out_stage.sv
module u2u_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  u2u_pkg::result_t load_res,
  output logic             out_valid,
  input  logic             out_ready,
  output u2u_pkg::result_t out_res,
  output logic             has_room
);

  logic             valid;
  logic             valid_next;
  u2u_pkg::result_t res;

  assign out_valid = valid;
  assign out_res   = res;
  assign has_room  = !valid || out_ready;

  // valid flag
  always_comb begin
    valid_next = valid;
    if (load) begin
      valid_next = 1'b1;
    end else if (out_ready) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (load) begin
      res <= load_res;
    end
  end

endmodule

>>> src/utf8_to_utf16_stream_decoder.sv
// utf-8 to utf-16 (bmp) stream decoder, one byte beat per cycle while not stalled
// a byte beat is held in the input register, its result in the result register
// throughput: one byte per cycle, set by the input register feeding the decode logic
// a stalled, full result register holds the decoder; input stops once both are full
// reset (rst, synchronous) empties both registers and clears the decoder state
module utf8_to_utf16_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] code_unit,
  output logic        is_error,
  output logic        last_unit
);

  u2u_pkg::item_t   in_item;
  u2u_pkg::item_t   held_item;
  u2u_pkg::result_t dec_res;
  u2u_pkg::result_t out_res;
  logic             held_valid;
  logic             has_room;
  logic             advance;
  logic             dec_valid;

  assign in_item.data_byte = data_byte;
  assign in_item.last_byte = last_byte;

  // held byte moves on when the result register can take its result
  assign advance = held_valid && has_room;

  // input register
  u2u_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // decode logic and sequence state
  u2u_decode u_dec (
    .clk        (clk),
    .rst        (rst),
    .item_valid (advance),
    .item       (held_item),
    .res_valid  (dec_valid),
    .res        (dec_res)
  );

  // result register
  u2u_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (dec_valid),
    .load_res  (dec_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res),
    .has_room  (has_room)
  );

  assign code_unit = out_res.code_unit;
  assign is_error  = out_res.is_error;
  assign last_unit = out_res.last_unit;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int N_ITEMS     = 850;
  localparam int MAX_GAP     = 6;
  localparam int HOLD_AT     = 120;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_WAIT  = 8;
  localparam int SHOW_MAX    = 10;

  // how a stimulus row gets its expectation
  localparam logic ROW_MODEL = 1'b0;
  localparam logic ROW_TYPED = 1'b1;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        typed;
    logic [15:0] code_unit;
    logic        is_error;
    logic        last_unit;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] code_unit;
  logic        is_error;
  logic        last_unit;

  // decoder state of the predictor
  logic [1:0]  dec_pend = u2u_pkg::PEND_NONE;
  logic [9:0]  dec_acc = '0;
  logic        dec_bad = 1'b0;

  stim_row_t          byte_rows [$];
  u2u_pkg::result_t   units_due [$];
  int          n_bytes = 0;
  int          n_units = 0;
  int          n_errors = 0;
  int          n_strings = 0;
  int          n_mismatch = 0;
  int          idle_cycles = 0;

  // directed strings: extremes, every sequence length, error cases
  stim_row_t dir_tab [25] = '{
    '{8'h00, 1'b1, ROW_TYPED, 16'h0000, 1'b0, 1'b1},
    '{8'h7F, 1'b1, ROW_TYPED, 16'h007F, 1'b0, 1'b1},
    '{8'hC2, 1'b0, ROW_MODEL, 16'h0000, 1'b0, 1'b0},
    '{8'hA9, 1'b1, ROW_MODEL, 16'h0000, 1'b0, 1'b0},
    '{8'hC0, 1'b0, ROW_MODEL, 16'h0000, 1'b0, 1'b0},
    '{8'h80, 1'b1, ROW_MODEL, 16'h0000, 1'b0, 1'b0},
    '{8'hDF, 1'b0, ROW_MODEL, 16'h0000, 1'b0, 1'b0},
    '{8'hBF, 1'b1, ROW_MODEL, 16'h0000, 1'b0, 1'b0},
    '{8'hE2, 1'b0, ROW_MODEL, 16'h0000, 1'b0, 1'b0},
    '{8'h82, 1'b0, ROW_MODEL, 16'h0000, 1'b0, 1'b0},
    '{8'hAC, 1'b1, ROW_MODEL, 16'h0000, 1'b0, 1'b0},
    '{8'hEF, 1'b0, ROW_MODEL, 16'h0000, 1'b0, 1'b0},
    '{8'hBF, 1'b0, ROW_MODEL, 16'h0000, 1'b0, 1'b0},
    '{8'hBF, 1'b1, ROW_MODEL, 16'h0000, 1'b0, 1'b0},
    '{8'hE0, 1'b0, ROW_MODEL, 16'h0000, 1'b0, 1'b0},
    '{8'h00, 1'b0, ROW_MODEL, 16'h0000, 1'b0, 1'b0},
    '{8'hFF, 1'b1, ROW_MODEL, 16'h0000, 1'b0, 1'b0},
    '{8'hFF, 1'b1, ROW_TYPED, 16'h0000, 1'b1, 1'b1},
    '{8'h80, 1'b1, ROW_TYPED, 16'h0000, 1'b1, 1'b1},
    '{8'hF0, 1'b0, ROW_MODEL, 16'h0000, 1'b0, 1'b0},
    '{8'h41, 1'b0, ROW_MODEL, 16'h0000, 1'b0, 1'b0},
    '{8'h42, 1'b1, ROW_TYPED, 16'h0000, 1'b1, 1'b1},
    '{8'hC3, 1'b1, ROW_TYPED, 16'h0000, 1'b1, 1'b1},
    '{8'hE4, 1'b0, ROW_MODEL, 16'h0000, 1'b0, 1'b0},
    '{8'hB8, 1'b1, ROW_TYPED, 16'h0000, 1'b1, 1'b1}
  };

  utf8_to_utf16_stream_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .code_unit (code_unit),
    .is_error  (is_error),
    .last_unit (last_unit)
  );

  always #2 clk = ~clk;

  // decode one byte beat, returns 1 when it yields a code unit
  function automatic bit decode_byte(input u2u_pkg::item_t beat,
                                     output u2u_pkg::result_t unit);
    logic [15:0] joined;
    unit = '0;
    joined = {dec_acc, 6'b0} | {8'h00, beat.data_byte & u2u_pkg::CONT_BITS};
    // rest of an invalid string is dropped until its end
    if (dec_bad) begin
      if (beat.last_byte) begin
        dec_bad = 1'b0;
        unit.is_error = 1'b1;
        unit.last_unit = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    // continuation byte, taken whatever its top bits
    if (dec_pend != u2u_pkg::PEND_NONE) begin
      dec_pend = dec_pend - 2'd1;
      if (dec_pend == u2u_pkg::PEND_NONE) begin
        dec_acc = '0;
        unit.code_unit = joined;
        unit.last_unit = beat.last_byte;
        return 1'b1;
      end
      dec_acc = joined[9:0];
      if (beat.last_byte) begin
        dec_pend = u2u_pkg::PEND_NONE;
        dec_acc = '0;
        unit.is_error = 1'b1;
        unit.last_unit = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    // lead byte
    if ((beat.data_byte & u2u_pkg::ASCII_MASK) == 8'h00) begin
      unit.code_unit = {8'h00, beat.data_byte};
      unit.last_unit = beat.last_byte;
      return 1'b1;
    end else if ((beat.data_byte & u2u_pkg::LEAD2_MASK) == u2u_pkg::LEAD2_CODE) begin
      dec_pend = u2u_pkg::PEND_ONE;
      dec_acc = {2'b00, beat.data_byte & u2u_pkg::LEAD2_BITS};
    end else if ((beat.data_byte & u2u_pkg::LEAD3_MASK) == u2u_pkg::LEAD3_CODE) begin
      dec_pend = u2u_pkg::PEND_TWO;
      dec_acc = {2'b00, beat.data_byte & u2u_pkg::LEAD3_BITS};
    end else begin
      dec_bad = 1'b1;
    end
    if (beat.last_byte) begin
      dec_pend = u2u_pkg::PEND_NONE;
      dec_acc = '0;
      dec_bad = 1'b0;
      unit.is_error = 1'b1;
      unit.last_unit = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 9) == 0)
      return 8'($urandom_range(0, 255));
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // one random string: mostly well formed, some bad leads and cut-off sequences
  task automatic add_random_string();
    logic [7:0] seq [$];
    stim_row_t  row;
    int n_chars;
    int kind;
    bit cut;
    n_chars = $urandom_range(1, 6);
    cut = 1'b0;
    for (int c = 0; c < n_chars && !cut; c++) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        seq.insert(seq.size(), 8'($urandom_range(0, 127)));
      end else if (kind < 65) begin
        seq.insert(seq.size(), 8'hC0 | 8'($urandom_range(0, 31)));
        seq.insert(seq.size(), cont_byte());
      end else if (kind < 87) begin
        seq.insert(seq.size(), 8'hE0 | 8'($urandom_range(0, 15)));
        seq.insert(seq.size(), cont_byte());
        seq.insert(seq.size(), cont_byte());
      end else if (kind < 94) begin
        if ($urandom_range(0, 1) == 1)
          seq.insert(seq.size(), 8'($urandom_range(8'h80, 8'hBF)));
        else
          seq.insert(seq.size(), 8'($urandom_range(8'hF0, 8'hFF)));
      end else begin
        // sequence cut short by the end of the string
        if ($urandom_range(0, 1) == 1) begin
          seq.insert(seq.size(), 8'hC0 | 8'($urandom_range(0, 31)));
        end else begin
          seq.insert(seq.size(), 8'hE0 | 8'($urandom_range(0, 15)));
          if ($urandom_range(0, 1) == 1)
            seq.insert(seq.size(), cont_byte());
        end
        cut = 1'b1;
      end
    end
    foreach (seq[i]) begin
      row = '0;
      row.data_byte = seq[i];
      row.last_byte = (i == seq.size() - 1);
      row.typed = ROW_MODEL;
      byte_rows.insert(byte_rows.size(), row);
    end
  endtask

  // byte beat sender
  initial begin
    int gap;
    foreach (dir_tab[i])
      byte_rows.insert(byte_rows.size(), dir_tab[i]);
    while (byte_rows.size() < N_ITEMS)
      add_random_string();

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    foreach (byte_rows[i]) begin
      gap = ((i % 160) < 30) ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid <= 1'b1;
      data_byte <= byte_rows[i].data_byte;
      last_byte <= byte_rows[i].last_byte;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      @(negedge clk);
    end
    in_valid <= 1'b0;

    // drain
    while (units_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (units_due.size() != 0)
      n_mismatch += units_due.size();

    $display("%0d bytes in %0d strings, %0d code units out, %0d error strings",
             n_bytes, n_strings, n_units, n_errors);
    $display("long output hold of %0d cycles done after %0d results",
             HOLD_CYCLES, HOLD_AT);
    if (n_mismatch == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("end of test: mismatches");
    end
    $finish;
  end

  // result receiver, with one long hold to back up the pipeline
  initial begin
    int stall;
    int taken;
    taken = 0;
    while (rst) @(negedge clk);
    forever begin
      if (taken == HOLD_AT)
        stall = HOLD_CYCLES;
      else if ((taken % 100) < 20)
        stall = 0;
      else
        stall = $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  // predict on byte beats, check on result beats
  always @(posedge clk) begin
    u2u_pkg::result_t got;
    u2u_pkg::result_t want;
    u2u_pkg::result_t pred;
    u2u_pkg::result_t due;
    u2u_pkg::item_t   beat_in;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.code_unit = code_unit;
        got.is_error  = is_error;
        got.last_unit = last_unit;
        n_units++;
        if (is_error) n_errors++;
        if (last_unit) n_strings++;
        if (units_due.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= SHOW_MAX)
            $display("unexpected unit: code %h err %b last %b", code_unit, is_error, last_unit);
        end else begin
          want = units_due.pop_front();
          if (got != want) begin
            n_mismatch++;
            if (n_mismatch <= SHOW_MAX)
              $display("unit %0d: exp code %h err %b last %b, got code %h err %b last %b",
                       n_units, want.code_unit, want.is_error, want.last_unit,
                       got.code_unit, got.is_error, got.last_unit);
          end
        end
      end
      if (in_valid && in_ready) begin
        beat_in.data_byte = data_byte;
        beat_in.last_byte = last_byte;
        if (decode_byte(beat_in, pred)) begin
          if (byte_rows[n_bytes].typed == ROW_TYPED) begin
            due.code_unit = byte_rows[n_bytes].code_unit;
            due.is_error  = byte_rows[n_bytes].is_error;
            due.last_unit = byte_rows[n_bytes].last_unit;
          end else begin
            due = pred;
          end
          units_due.insert(units_due.size(), due);
        end
        n_bytes++;
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
